// ===== hw/rtl/ppg_beat_detector_unit_assert.svh =====
// Assertion macros for the beat detector checker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef PPG_BEAT_DETECTOR_UNIT_ASSERT_SVH
`define PPG_BEAT_DETECTOR_UNIT_ASSERT_SVH

// Check outside reset only.
`define PPGBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check at every edge, reset included.
`define PPGBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/ppgbd_pkg.sv =====
// Shared types, constants and filter coefficients of the beat detector.
// No dependencies.
package ppgbd_pkg;

  localparam int unsigned FILT_W     = 30;
  localparam int unsigned SWING_W    = 30;
  localparam int unsigned RISE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 30;
  localparam int unsigned COEF_W     = 14;
  localparam int unsigned TAP_IDX_W  = 4;
  localparam int unsigned BACK_W     = 5;
  localparam int unsigned NUM_TAPS   = 23;
  localparam int unsigned FIR_SHIFT  = 8;

  localparam logic [TAP_IDX_W-1:0] CENTER_TAP = TAP_IDX_W'(11);

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SWING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SWING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_RUN  = 2'd2;

  localparam logic [SWING_W-1:0] MIN_SWING_RST = 30'd75;
  localparam logic [SWING_W-1:0] MAX_SWING_RST = 30'd2500000;
  localparam logic [RISE_W-1:0]  RISE_RUN_RST  = 3'd5;

  typedef struct packed {
    logic [SWING_W-1:0] min_swing;
    logic [SWING_W-1:0] max_swing;
    logic [RISE_W-1:0]  rise_run_needed;
  } ppgbd_cfg_t;

  typedef struct packed {
    logic mul;
    logic clr;
    logic acc;
  } ppgbd_mac_ctrl_t;

  function automatic logic signed [COEF_W-1:0] fir_coef(input logic [TAP_IDX_W-1:0] k);
    logic signed [COEF_W-1:0] c;
    case (k)
      4'd0:    c = -14'sd111;
      4'd1:    c = -14'sd83;
      4'd2:    c = -14'sd10;
      4'd3:    c = 14'sd202;
      4'd4:    c = 14'sd603;
      4'd5:    c = 14'sd1212;
      4'd6:    c = 14'sd2009;
      4'd7:    c = 14'sd2923;
      4'd8:    c = 14'sd3842;
      4'd9:    c = 14'sd4632;
      4'd10:   c = 14'sd5167;
      4'd11:   c = 14'sd5356;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/ppgbd_if.sv =====
// Valid/ready channel interfaces of the beat detector: sample, result, config.
// Depends on ppgbd_pkg.
interface ppgbd_in_if #(parameter int unsigned SAMPLE_BITS = 18);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface ppgbd_out_if import ppgbd_pkg::*; #(parameter int unsigned SAMPLE_BITS = 18);
  logic                     valid;
  logic                     ready;
  logic                     beat;
  logic signed [FILT_W-1:0] filtered;
  logic [SAMPLE_BITS-1:0]   dc_average;
  modport source (output valid, output beat, output filtered, output dc_average, input ready);
  modport sink   (input valid, input beat, input filtered, input dc_average, output ready);
endinterface

interface ppgbd_cfg_if import ppgbd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== hw/rtl/ppgbd_mac.sv =====
// Shared signed multiplier with product register and accumulator.
// Depends on ppgbd_pkg for the control struct.
module ppgbd_mac import ppgbd_pkg::*; #(
  parameter int unsigned A_W   = 22,
  parameter int unsigned B_W   = 22,
  parameter int unsigned ACC_W = 41
) (
  input  logic                        clk_i,
  input  ppgbd_mac_ctrl_t             ctrl_i,
  input  logic signed [A_W-1:0]       a_i,
  input  logic signed [B_W-1:0]       b_i,
  output logic signed [A_W+B_W-1:0]   prod_o,
  output logic signed [ACC_W-1:0]     acc_o
);

  logic signed [A_W+B_W-1:0] prod_q;
  logic signed [ACC_W-1:0]   acc_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= a_i * b_i;
    end
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

// ===== hw/rtl/ppgbd_shape.sv =====
// Peak/valley shape rules, rising-run count and beat decision.
// Depends on ppgbd_pkg for the configuration struct.
module ppgbd_shape import ppgbd_pkg::*; #(
  parameter int unsigned Y_W = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic signed [Y_W-1:0] y0_i,
  input  ppgbd_cfg_t            cfg_i,
  output logic                  beat_o
);

  localparam int unsigned SW_W = (Y_W + 1 > SWING_W + 1) ? Y_W + 1 : SWING_W + 1;

  logic signed [Y_W-1:0] y1_q, y2_q, peak_q, valley_q;
  logic signed [Y_W-1:0] peak_d, valley_d;
  logic                  mpeak_q, mvalley_q, pseen_q, vseen_q;
  logic                  mpeak_d, mvalley_d, pseen_d, vseen_d;
  logic [RISE_W-1:0]     rise_q, rise_d;
  logic signed [SW_W-1:0] swing, min_s, max_s;
  logic                  beat;

  always_comb begin
    mpeak_d   = mpeak_q;
    mvalley_d = mvalley_q;
    pseen_d   = pseen_q;
    vseen_d   = vseen_q;
    peak_d    = peak_q;
    valley_d  = valley_q;
    rise_d    = rise_q;
    beat      = 1'b0;

    if (y2_q == y1_q && y1_q < y0_i) begin
      if (mvalley_d) begin
        vseen_d   = 1'b1;
        valley_d  = y1_q;
        mvalley_d = 1'b0;
      end
      mpeak_d = 1'b0;
    end
    if (y2_q == y1_q && y1_q > y0_i) begin
      mvalley_d = 1'b0;
      if (mpeak_d && y1_q > 0) begin
        mpeak_d = 1'b0;
        pseen_d = 1'b1;
        peak_d  = y1_q;
      end
    end
    if (y2_q < y1_q && y1_q == y0_i) begin
      mpeak_d = 1'b1;
    end
    if (y2_q < y1_q && y1_q > y0_i && y1_q > 0) begin
      pseen_d = 1'b1;
      peak_d  = y1_q;
    end
    if (y2_q > y1_q && y1_q < y0_i) begin
      vseen_d  = 1'b1;
      valley_d = y1_q;
    end
    if (y2_q > y1_q && y1_q == y0_i) begin
      mvalley_d = 1'b1;
    end

    if (rise_d < cfg_i.rise_run_needed) begin
      rise_d = (y1_q <= y0_i) ? rise_d + 1'b1 : '0;
    end

    swing = SW_W'(peak_d) - SW_W'(valley_d);
    min_s = SW_W'($signed({1'b0, cfg_i.min_swing}));
    max_s = SW_W'($signed({1'b0, cfg_i.max_swing}));

    if (pseen_d) begin
      beat      = vseen_d && (rise_d == cfg_i.rise_run_needed) &&
                  (swing > min_s) && (swing < max_s);
      mpeak_d   = 1'b0;
      mvalley_d = 1'b0;
      pseen_d   = 1'b0;
      vseen_d   = 1'b0;
      rise_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y1_q      <= '0;
      y2_q      <= '0;
      peak_q    <= '0;
      valley_q  <= '0;
      mpeak_q   <= 1'b0;
      mvalley_q <= 1'b0;
      pseen_q   <= 1'b0;
      vseen_q   <= 1'b0;
      rise_q    <= '0;
    end else if (step_i) begin
      y2_q      <= y1_q;
      y1_q      <= y0_i;
      peak_q    <= peak_d;
      valley_q  <= valley_d;
      mpeak_q   <= mpeak_d;
      mvalley_q <= mvalley_d;
      pseen_q   <= pseen_d;
      vseen_q   <= vseen_d;
      rise_q    <= rise_d;
    end
  end

  assign beat_o = beat;

endmodule

// ===== hw/rtl/ppg_beat_detector_unit.sv =====
// Optical pulse beat detector: DC removal, 23-tap low-pass FIR and beat decision.
// Depends on ppgbd_pkg, ppgbd_if, ppgbd_mac and ppgbd_shape.
//
// A sample request is taken only in the idle state, so the next one waits until
// the last is through: the sequencer accepts it, runs the two moving averages
// (each a reciprocal multiply on the shared multiplier), the symmetric tap pairs
// through that same multiplier, drains the read/multiply/accumulate pipeline
// and applies the shape rules. The result register holds one finished result;
// while it stays full the sequencer waits before its last step. The delay line
// is a single-write, dual-read memory; a fill count stands in for its zero
// reset, so there is no clearing pass. Configuration writes are taken in any
// cycle.
module ppg_beat_detector_unit import ppgbd_pkg::*; #(
  parameter int unsigned AVG_DEPTH   = 4,
  parameter int unsigned DELAY_DEPTH = 32,
  parameter int unsigned SAMPLE_BITS = 18
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppgbd_in_if.sink    in_i,
  ppgbd_out_if.source out_o,
  ppgbd_cfg_if.sink   cfg_i
);

  localparam int unsigned L_AVG  = $clog2(AVG_DEPTH);
  localparam int unsigned SUM_W  = SAMPLE_BITS + L_AVG;
  localparam int unsigned RCP_SH = SUM_W + L_AVG;
  localparam int unsigned RCP_W  = SUM_W + 2;
  localparam int unsigned HP_W   = SAMPLE_BITS + 3;
  localparam int unsigned PAIR_W = HP_W + 1;
  localparam int unsigned ACC_W  = HP_W + 17;
  localparam int unsigned Y_W    = ACC_W - 7;
  localparam int unsigned SLOT_W = $clog2(DELAY_DEPTH);
  localparam int unsigned OPA_W  = (RCP_W + 1 > COEF_W) ? RCP_W + 1 : COEF_W;
  localparam int unsigned OPB_W  = (SUM_W + 1 > PAIR_W) ? SUM_W + 1 : PAIR_W;
  localparam int unsigned PROD_W = OPA_W + OPB_W;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << RCP_SH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));
  localparam logic [BACK_W-1:0] FILL_MAX = BACK_W'(NUM_TAPS);
  localparam logic [BACK_W-1:0] LAST_BACK = BACK_W'(NUM_TAPS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL1  = 3'd1;
  localparam logic [2:0] S_AVG1  = 3'd2;
  localparam logic [2:0] S_MUL2  = 3'd3;
  localparam logic [2:0] S_AVG2  = 3'd4;
  localparam logic [2:0] S_FIR   = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_SHAPE = 3'd7;

  logic [2:0]             state_q, state_d;
  ppgbd_cfg_t             cfg_q;
  logic [SAMPLE_BITS-1:0] samp_ring_q [AVG_DEPTH];
  logic [SAMPLE_BITS-1:0] avg_ring_q  [AVG_DEPTH];
  logic [SUM_W-1:0]       samp_sum_q, avg_sum_q;
  logic [SAMPLE_BITS-1:0] avg_new, dc_q;
  logic signed [SAMPLE_BITS:0] dc_diff;
  logic signed [HP_W-1:0] hp;
  logic signed [HP_W-1:0] dline_q [DELAY_DEPTH];
  logic [SLOT_W-1:0]      slot_q;
  logic [BACK_W-1:0]      fill_q;
  logic [TAP_IDX_W-1:0]   rk_q, rd_k_q;
  logic [BACK_W-1:0]      back_a, back_b;
  logic [SLOT_W-1:0]      addr_a, addr_b;
  logic                   rd_v_q, mul_v_q, va_q, vb_q;
  logic signed [HP_W-1:0] rd_a_q, rd_b_q;
  logic signed [PAIR_W-1:0] pair;
  ppgbd_mac_ctrl_t        mac_ctrl;
  logic signed [OPA_W-1:0] mac_a;
  logic signed [OPB_W-1:0] mac_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_sh;
  logic signed [Y_W-1:0]   y0_q;
  logic                    accept, drained, out_free, step;
  logic                    beat;
  logic                    out_valid_q, out_beat_q;

  assign accept   = in_i.valid && in_i.ready;
  assign drained  = !rd_v_q && !mul_v_q;
  assign out_free = !out_valid_q || out_o.ready;
  assign step     = (state_q == S_SHAPE) && out_free;
  assign avg_new  = prod[RCP_SH +: SAMPLE_BITS];
  assign dc_diff  = $signed({1'b0, avg_new}) - $signed({1'b0, samp_ring_q[AVG_DEPTH-1]});
  assign hp       = {dc_diff, 2'b00};
  assign acc_sh   = acc >>> FIR_SHIFT;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_MUL1;
      S_MUL1:  state_d = S_AVG1;
      S_AVG1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_AVG2;
      S_AVG2:  state_d = S_FIR;
      S_FIR:   if (rk_q == CENTER_TAP) state_d = S_DRAIN;
      S_DRAIN: if (drained) state_d = S_SHAPE;
      S_SHAPE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_swing       <= MIN_SWING_RST;
      cfg_q.max_swing       <= MAX_SWING_RST;
      cfg_q.rise_run_needed <= RISE_RUN_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_MIN_SWING: cfg_q.min_swing       <= cfg_i.wdata;
        CFG_MAX_SWING: cfg_q.max_swing       <= cfg_i.wdata;
        CFG_RISE_RUN:  cfg_q.rise_run_needed <= cfg_i.wdata[RISE_W-1:0];
        default:       cfg_q <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AVG_DEPTH; i++) begin
        samp_ring_q[i] <= '0;
        avg_ring_q[i]  <= '0;
      end
      samp_sum_q <= '0;
      avg_sum_q  <= '0;
      slot_q     <= '0;
      fill_q     <= '0;
    end else begin
      if (accept) begin
        samp_ring_q[0] <= in_i.sample;
        for (int i = 1; i < AVG_DEPTH; i++) begin
          samp_ring_q[i] <= samp_ring_q[i-1];
        end
        samp_sum_q <= samp_sum_q - SUM_W'(samp_ring_q[AVG_DEPTH-1]) + SUM_W'(in_i.sample);
      end
      if (state_q == S_AVG1) begin
        avg_ring_q[0] <= avg_new;
        for (int i = 1; i < AVG_DEPTH; i++) begin
          avg_ring_q[i] <= avg_ring_q[i-1];
        end
        avg_sum_q <= avg_sum_q - SUM_W'(avg_ring_q[AVG_DEPTH-1]) + SUM_W'(avg_new);
      end
      if (state_q == S_AVG2 && fill_q != FILL_MAX) begin
        fill_q <= fill_q + 1'b1;
      end
      if (step) begin
        slot_q <= (slot_q == SLOT_W'(DELAY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
      end
    end
  end

  assign back_a = BACK_W'(rk_q);
  assign back_b = LAST_BACK - back_a;

  always_comb begin
    if ({1'b0, slot_q} >= (SLOT_W + 1)'(back_a)) begin
      addr_a = SLOT_W'({1'b0, slot_q} - (SLOT_W + 1)'(back_a));
    end else begin
      addr_a = SLOT_W'({1'b0, slot_q} + (SLOT_W + 1)'(DELAY_DEPTH) - (SLOT_W + 1)'(back_a));
    end
    if ({1'b0, slot_q} >= (SLOT_W + 1)'(back_b)) begin
      addr_b = SLOT_W'({1'b0, slot_q} - (SLOT_W + 1)'(back_b));
    end else begin
      addr_b = SLOT_W'({1'b0, slot_q} + (SLOT_W + 1)'(DELAY_DEPTH) - (SLOT_W + 1)'(back_b));
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_AVG2) begin
      dline_q[slot_q] <= hp;
      dc_q            <= avg_new;
    end
    rd_a_q <= dline_q[addr_a];
    rd_b_q <= dline_q[addr_b];
    rd_k_q <= rk_q;
    if (state_q == S_DRAIN && drained) begin
      y0_q <= Y_W'(-acc_sh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rk_q    <= '0;
      rd_v_q  <= 1'b0;
      mul_v_q <= 1'b0;
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
    end else begin
      if (state_q == S_AVG2) begin
        rk_q <= '0;
      end else if (state_q == S_FIR) begin
        rk_q <= rk_q + 1'b1;
      end
      rd_v_q  <= (state_q == S_FIR);
      mul_v_q <= rd_v_q;
      va_q    <= back_a < fill_q;
      vb_q    <= (back_b < fill_q) && (rk_q != CENTER_TAP);
    end
  end

  always_comb begin
    pair = (va_q ? PAIR_W'(rd_a_q) : '0) + (vb_q ? PAIR_W'(rd_b_q) : '0);
    mac_ctrl.mul = (state_q == S_MUL1) || (state_q == S_MUL2) || rd_v_q;
    mac_ctrl.clr = (state_q == S_AVG2);
    mac_ctrl.acc = mul_v_q;
    if (rd_v_q) begin
      mac_a = OPA_W'(fir_coef(rd_k_q));
      mac_b = OPB_W'(pair);
    end else begin
      mac_a = OPA_W'($signed({1'b0, RECIP}));
      mac_b = (state_q == S_MUL2) ? OPB_W'($signed({1'b0, avg_sum_q}))
                                  : OPB_W'($signed({1'b0, samp_sum_q}));
    end
  end

  ppgbd_mac #(
    .A_W   (OPA_W),
    .B_W   (OPB_W),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .prod_o (prod),
    .acc_o  (acc)
  );

  ppgbd_shape #(
    .Y_W (Y_W)
  ) u_shape (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .y0_i   (y0_q),
    .cfg_i  (cfg_q),
    .beat_o (beat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  logic signed [FILT_W-1:0] out_filt_q;
  logic [SAMPLE_BITS-1:0]   out_dc_q;

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_beat_q <= beat;
      out_filt_q <= FILT_W'(y0_q);
      out_dc_q   <= dc_q;
    end
  end

  assign in_i.ready       = (state_q == S_IDLE);
  assign cfg_i.ready      = 1'b1;
  assign out_o.valid      = out_valid_q;
  assign out_o.beat       = out_beat_q;
  assign out_o.filtered   = out_filt_q;
  assign out_o.dc_average = out_dc_q;

endmodule

// ===== hw/rtl/ppgbd_checker.sv =====
// Port-level checker for the beat detector, bound to the top level.
// Depends on ppgbd_pkg and ppg_beat_detector_unit_assert.svh.
`include "ppg_beat_detector_unit_assert.svh"

module ppgbd_checker import ppgbd_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 18
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic                     out_beat_i,
  input logic signed [FILT_W-1:0] out_filtered_i,
  input logic [SAMPLE_BITS-1:0]   out_dc_i
);

  `PPGBD_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |=> !out_valid_i, "result valid in reset")
  `PPGBD_ASSERT(a_busy_after_request, in_valid_i && in_ready_i |=> !in_ready_i, "ready right after request")
  `PPGBD_ASSERT(a_no_instant_result, $rose(out_valid_i) |-> !$past(in_valid_i && in_ready_i), "result one cycle after request")
  `PPGBD_ASSERT(a_result_holds, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_beat_i) && $stable(out_filtered_i) && $stable(out_dc_i), "stalled result changed")

endmodule

bind ppg_beat_detector_unit ppgbd_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_ppgbd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_beat_i     (out_o.beat),
  .out_filtered_i (out_o.filtered),
  .out_dc_i       (out_o.dc_average)
);

// ===== tb/tb_ppg_beat_detector_unit.sv =====
// Self-checking testbench of ppg_beat_detector_unit: directed samples, then pulse trains and noise.
// A local predictor of the DC removal, FIR and beat rules checks results not fixed by typed rows.
// Depends on ppgbd_pkg, ppgbd_if and the ppg_beat_detector_unit RTL.
module tb_ppg_beat_detector_unit;
  import ppgbd_pkg::*;

  localparam int SMP_W = 18;
  localparam int SMP_MAX = (1 << SMP_W) - 1;
  localparam int AVG_N = 4;
  localparam int DLY_N = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_DIRECTED = 24;
  localparam int N_PHASES = 6;
  localparam int PHASE_ITEMS = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [CFG_DATA_W-1:0] DATA_ONES = '1;

  typedef struct packed {
    logic               beat;
    logic [FILT_W-1:0]  filtered;
    logic [SMP_W-1:0]   dc_average;
  } beat_res_t;

  typedef struct packed {
    logic [SMP_W-1:0] sample;
    logic             typed;
    beat_res_t        res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ppgbd_in_if #(.SAMPLE_BITS(SMP_W)) in_if ();
  ppgbd_out_if #(.SAMPLE_BITS(SMP_W)) out_if ();
  ppgbd_cfg_if cfg_if ();

  ppg_beat_detector_unit #(
    .AVG_DEPTH  (AVG_N),
    .DELAY_DEPTH(DLY_N),
    .SAMPLE_BITS(SMP_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  longint fir_tap [12] = '{-111, -83, -10, 202, 603, 1212, 2009, 2923, 3842, 4632, 5167, 5356};

  dir_row_t dir_rows [N_DIRECTED] = '{
    '{18'd0, 1'b1, '0}, '{18'd0, 1'b1, '0}, '{18'd0, 1'b1, '0},
    '{18'd262143, 1'b0, '0}, '{18'd262143, 1'b0, '0}, '{18'd262143, 1'b0, '0},
    '{18'd262143, 1'b0, '0}, '{18'd262143, 1'b0, '0}, '{18'd262143, 1'b0, '0},
    '{18'd262143, 1'b0, '0}, '{18'd262143, 1'b0, '0},
    '{18'd0, 1'b0, '0}, '{18'd0, 1'b0, '0}, '{18'd0, 1'b0, '0}, '{18'd0, 1'b0, '0},
    '{18'd262143, 1'b0, '0}, '{18'd0, 1'b0, '0}, '{18'd262143, 1'b0, '0},
    '{18'd0, 1'b0, '0},
    '{18'd1, 1'b0, '0}, '{18'd131072, 1'b0, '0}, '{18'd131071, 1'b0, '0},
    '{18'd174762, 1'b0, '0}, '{18'd87381, 1'b0, '0}
  };

  // detector state
  logic [SMP_W-1:0]      smp_ring [AVG_N];
  logic [SMP_W-1:0]      avg_ring [AVG_N];
  int                    dc_idx;
  longint                dly_line [DLY_N];
  int                    fir_idx;
  longint                y_last;
  longint                y_older;
  bit                    peak_pending;
  bit                    valley_pending;
  bit                    peak_seen;
  bit                    valley_seen;
  int                    rise_cnt;
  longint                peak_val;
  longint                valley_val;
  logic [SWING_W-1:0]    min_swing;
  logic [SWING_W-1:0]    max_swing;
  logic [RISE_W-1:0]     rise_needed;

  beat_res_t beat_reports_q [$];
  beat_res_t want;
  int        n_mismatch = 0;
  int        n_cycles = 0;
  int        stall_left = 0;
  bit        quiet = 1'b0;

  function automatic beat_res_t detect_beat(input logic [SMP_W-1:0] s);
    longint unsigned acc;
    longint hp, z, y0, y1, y2, swing;
    logic [SMP_W-1:0] dc;
    bit beat_now;
    beat_res_t r;
    beat_now = 1'b0;
    smp_ring[dc_idx] = s;
    acc = 0;
    for (int i = 0; i < AVG_N; i++) acc += smp_ring[i];
    avg_ring[dc_idx] = SMP_W'(acc / AVG_N);
    acc = 0;
    for (int i = 0; i < AVG_N; i++) acc += avg_ring[i];
    dc = SMP_W'(acc / AVG_N);
    hp = (longint'(dc) - longint'(smp_ring[(dc_idx + 1) % AVG_N])) * 4;
    dc_idx = (dc_idx + 1) % AVG_N;

    dly_line[fir_idx] = hp;
    z = fir_tap[11] * dly_line[(fir_idx + 2 * DLY_N - 11) % DLY_N];
    for (int i = 0; i < 11; i++)
      z += fir_tap[i] * (dly_line[(fir_idx + 2 * DLY_N - i) % DLY_N] +
                         dly_line[(fir_idx + 2 * DLY_N - (22 - i)) % DLY_N]);
    fir_idx = (fir_idx + 1) % DLY_N;
    y0 = -(z >>> FIR_SHIFT);
    y2 = y_older;
    y1 = y_last;

    if (y2 == y1 && y1 < y0) begin
      if (valley_pending) begin
        valley_seen = 1'b1;
        valley_val = y1;
        valley_pending = 1'b0;
      end
      peak_pending = 1'b0;
    end
    if (y2 == y1 && y1 > y0) begin
      valley_pending = 1'b0;
      if (peak_pending && y1 > 0) begin
        peak_pending = 1'b0;
        peak_seen = 1'b1;
        peak_val = y1;
      end
    end
    if (y2 < y1 && y1 == y0) peak_pending = 1'b1;
    if (y2 < y1 && y1 > y0 && y1 > 0) begin
      peak_seen = 1'b1;
      peak_val = y1;
    end
    if (y2 > y1 && y1 < y0) begin
      valley_seen = 1'b1;
      valley_val = y1;
    end
    if (y2 > y1 && y1 == y0) valley_pending = 1'b1;

    if (rise_cnt < int'(rise_needed)) begin
      if (y1 <= y0) rise_cnt++;
      else rise_cnt = 0;
    end

    if (peak_seen) begin
      swing = peak_val - valley_val;
      if (valley_seen && rise_cnt == int'(rise_needed) &&
          swing > longint'(min_swing) && swing < longint'(max_swing))
        beat_now = 1'b1;
      peak_pending = 1'b0;
      valley_pending = 1'b0;
      peak_seen = 1'b0;
      valley_seen = 1'b0;
      rise_cnt = 0;
    end

    y_older = y1;
    y_last = y0;
    r.beat = beat_now;
    r.filtered = FILT_W'(y0);
    r.dc_average = dc;
    return r;
  endfunction

  task automatic clear_detector();
    for (int i = 0; i < AVG_N; i++) begin
      smp_ring[i] = '0;
      avg_ring[i] = '0;
    end
    for (int i = 0; i < DLY_N; i++) dly_line[i] = 0;
    dc_idx = 0;
    fir_idx = 0;
    y_last = 0;
    y_older = 0;
    peak_pending = 1'b0;
    valley_pending = 1'b0;
    peak_seen = 1'b0;
    valley_seen = 1'b0;
    rise_cnt = 0;
    peak_val = 0;
    valley_val = 0;
    min_swing = MIN_SWING_RST;
    max_swing = MAX_SWING_RST;
    rise_needed = RISE_RUN_RST;
  endtask

  task automatic push_sample(input logic [SMP_W-1:0] s, input bit typed, input beat_res_t fixed);
    beat_res_t predicted;
    if (!quiet && $urandom_range(99) < 8) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.sample <= s;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = detect_beat(s);
    beat_reports_q.push_back(typed ? fixed : predicted);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (beat_reports_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_MIN_SWING: min_swing = val;
      CFG_MAX_SWING: max_swing = val;
      CFG_RISE_RUN:  rise_needed = val[RISE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                                input logic [CFG_DATA_W-1:0] run);
    write_reg(CFG_MIN_SWING, lo);
    write_reg(CFG_MAX_SWING, hi);
    write_reg(CFG_RISE_RUN, run);
    if ($urandom_range(1) == 1) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_pulses(input int n);
    int period, rise_len, amp, base, noise, ph, tri_v, v;
    period = $urandom_range(10, 60);
    rise_len = $urandom_range(2, period / 2);
    amp = ($urandom_range(9) == 0) ? $urandom_range(3000, 60000) : $urandom_range(20, 3000);
    base = $urandom_range(amp, SMP_MAX - amp);
    noise = $urandom_range(0, 8);
    for (int t = 0; t < n; t++) begin
      ph = t % period;
      if (ph < rise_len) tri_v = amp * ph / rise_len;
      else tri_v = amp * (period - ph) / (period - rise_len);
      v = base + tri_v + $urandom_range(0, 2 * noise) - noise;
      if (v < 0) v = 0;
      if (v > SMP_MAX) v = SMP_MAX;
      push_sample(SMP_W'(v), 1'b0, '0);
    end
  endtask

  task automatic send_noise(input int n);
    int center;
    center = $urandom_range(0, SMP_MAX);
    for (int t = 0; t < n; t++) begin
      if ($urandom_range(1) == 0) push_sample(SMP_W'($urandom), 1'b0, '0);
      else push_sample(SMP_W'(center + $urandom_range(0, 255)), 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (beat_reports_q.size() == 0) begin
        $error("result request with nothing pending");
        n_mismatch++;
      end else begin
        want = beat_reports_q.pop_front();
        if (out_if.beat !== want.beat) begin
          $error("beat: expected %0d, got %0d", want.beat, out_if.beat);
          n_mismatch++;
        end
        if (out_if.filtered !== want.filtered) begin
          $error("filtered: expected %0d, got %0d", $signed(want.filtered),
                 $signed(out_if.filtered));
          n_mismatch++;
        end
        if (out_if.dc_average !== want.dc_average) begin
          $error("dc_average: expected %0d, got %0d", want.dc_average, out_if.dc_average);
          n_mismatch++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(999) < 6) begin
      stall_left = $urandom_range(0, 29);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int sent;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.sample = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.wdata = '0;
    out_if.ready = 1'b0;
    clear_detector();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++)
      push_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].res);

    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      quiet = (p == 1);
      case (p)
        0: set_thresholds(CFG_DATA_W'(75), CFG_DATA_W'(2500000), CFG_DATA_W'(5));
        1: set_thresholds('0, DATA_ONES, CFG_DATA_W'(7));
        2: set_thresholds('0, DATA_ONES, CFG_DATA_W'(0));
        3: set_thresholds(DATA_ONES, '0, CFG_DATA_W'(1));
        4: set_thresholds(CFG_DATA_W'($urandom_range(0, 2000)),
                          CFG_DATA_W'($urandom_range(100000, 1073741823)),
                          CFG_DATA_W'($urandom_range(1, 7)));
        default: set_thresholds(CFG_DATA_W'($urandom_range(0, 500)),
                                CFG_DATA_W'($urandom_range(500000, 5000000)),
                                CFG_DATA_W'($urandom_range(2, 6)));
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(99) < 80) begin
          int n;
          n = $urandom_range(20, 60);
          send_pulses(n);
          sent += n;
        end else begin
          int n;
          n = $urandom_range(5, 15);
          send_noise(n);
          sent += n;
        end
      end
    end

    quiet = 1'b0;
    drain_results();
    repeat (40) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
